// ===== rtl/core/bht_pkg.sv =====
// Shared types and constants for the bounding box hit test table.
`default_nettype none

package bht_pkg;

   // Default table size and coordinate width
   localparam int MAX_BOXES  = 16;
   localparam int COORD_BITS = 11;

   // Widths of the transaction fields
   localparam int POINT_W = 11;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;

   // Request opcodes
   typedef enum logic [1:0] {
      OP_CLICK = 2'd0,
      OP_START = 2'd1,
      OP_END   = 2'd2,
      OP_HIDE  = 2'd3
   } opcode_type;

   // Response status codes
   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_NO_SEL = 2'd2,
      STAT_EMPTY  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [POINT_W-1:0] point_x;
      logic [POINT_W-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic               hit_found;
      logic [INDEX_W-1:0] hit_index;
      logic [COUNT_W-1:0] box_count;
      logic [1:0]         status;
   } rsp_type;

   // Probe token control that walks the cell row
   typedef struct packed {
      logic active;
      logic found;
   } probe_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/bht_cell.sv =====
// One table entry: stored box, visible flag and one stage of the probe row.
`default_nettype none

module bht_cell #(
   parameter int CW    = bht_pkg::COORD_BITS,
   parameter int IW    = 4,
   parameter int INDEX = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // entry writes
   input  wire logic                    commit_en,
   input  wire logic [4*CW-1:0]         commit_box,
   input  wire logic                    hide_en,
   // probe from the previous cell
   input  wire bht_pkg::probe_ctrl_type probe_in,
   input  wire logic [CW-1:0]           x_in,
   input  wire logic [CW-1:0]           y_in,
   input  wire logic [IW-1:0]           idx_in,
   // probe to the next cell
   output      bht_pkg::probe_ctrl_type probe_out,
   output      logic [CW-1:0]           x_out,
   output      logic [CW-1:0]           y_out,
   output      logic [IW-1:0]           idx_out
);

   localparam logic [IW-1:0] MyIdx = IW'(INDEX);

   logic [4*CW-1:0]         box_ff;
   logic                    visible_ff, visible_in;
   bht_pkg::probe_ctrl_type probe_ff, probe_fwd_in;
   logic [CW-1:0]           x_ff, y_ff;
   logic [IW-1:0]           idx_ff, idx_fwd_in;
   logic [CW-1:0]           xmin, xmax, ymin, ymax;
   logic                    hit;

   // box layout: xmin, xmax, ymin, ymax from the top
   assign xmin = box_ff[4*CW-1:3*CW];
   assign xmax = box_ff[3*CW-1:2*CW];
   assign ymin = box_ff[2*CW-1:CW];
   assign ymax = box_ff[CW-1:0];

   // inclusive hit, only for the first visible match along the row
   assign hit = probe_in.active && !probe_in.found && visible_ff &&
                (x_in >= xmin) && (x_in <= xmax) &&
                (y_in >= ymin) && (y_in <= ymax);

   always_comb begin
      probe_fwd_in.active = probe_in.active;
      probe_fwd_in.found  = probe_in.found || hit;
      idx_fwd_in          = hit ? MyIdx : idx_in;
   end

   // visibility: commit sets, hide clears
   always_comb begin
      visible_in = visible_ff;
      if (commit_en) begin
         visible_in = 1'b1;
      end else if (hide_en) begin
         visible_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visible_ff <= 1'b0;
         probe_ff   <= '0;
      end else begin
         visible_ff <= visible_in;
         probe_ff   <= probe_fwd_in;
      end
   end

   // payload: stored box and probe data
   always_ff @(posedge clock) begin
      if (commit_en) begin
         box_ff <= commit_box;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      idx_ff <= idx_fwd_in;
   end

   assign probe_out = probe_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign idx_out   = idx_ff;

endmodule

`default_nettype wire

// ===== rtl/core/box_hit_test_table.sv =====
// Top level of the bounding box hit test table.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   bht_pkg::req_type
//   rsp      out        rsp_valid / rsp_ready   bht_pkg::rsp_type
//
// A click walks the row of entry cells, one cell per cycle, and its result
// is registered once the probe leaves the last cell.
// Start, end and hide transactions have their result registered in the cycle after accept.
// One request is in flight at a time; a new one is taken once no click scan is running and
// the result register is empty or being drained in the same cycle.
// Synchronous active-high reset clears all control state; no clearing pass.
`default_nettype none

module box_hit_test_table #(
   parameter int MAX_BOXES  = bht_pkg::MAX_BOXES,
   parameter int COORD_BITS = bht_pkg::COORD_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire bht_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      bht_pkg::rsp_type rsp_data
);

   localparam int IW    = $clog2(MAX_BOXES);
   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam int CW    = COORD_BITS;
   localparam int EXT_W = (COORD_BITS > bht_pkg::POINT_W) ? COORD_BITS : bht_pkg::POINT_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic             building_ff, building_in;
   logic             run_has_ff, run_has_in;
   logic [CW-1:0]    run_xmin_ff, run_xmax_ff, run_ymin_ff, run_ymax_ff;
   logic [CW-1:0]    run_xmin_in, run_xmax_in, run_ymin_in, run_ymax_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic             sel_valid_ff, sel_valid_in;
   logic [IW-1:0]    sel_idx_ff, sel_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bht_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             req_fire, is_click, is_start, is_end, is_hide;
   logic             table_full, do_commit, do_hide;
   logic [EXT_W-1:0] x_ext, y_ext;
   logic [CW-1:0]    x_pt, y_pt;
   logic             scan_done;
   bht_pkg::status_type stat;

   // probe row taps: index 0 feeds cell 0, index MAX_BOXES is the tail
   bht_pkg::probe_ctrl_type probe_chain [0:MAX_BOXES];
   logic [CW-1:0]           x_chain     [0:MAX_BOXES];
   logic [CW-1:0]           y_chain     [0:MAX_BOXES];
   logic [IW-1:0]           idx_chain   [0:MAX_BOXES];

   // request decode
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign is_click  = req_fire && (req_data.opcode == bht_pkg::OP_CLICK);
   assign is_start  = req_fire && (req_data.opcode == bht_pkg::OP_START);
   assign is_end    = req_fire && (req_data.opcode == bht_pkg::OP_END);
   assign is_hide   = req_fire && (req_data.opcode == bht_pkg::OP_HIDE);

   assign x_ext = EXT_W'(req_data.point_x);
   assign y_ext = EXT_W'(req_data.point_y);
   assign x_pt  = x_ext[CW-1:0];
   assign y_pt  = y_ext[CW-1:0];

   assign table_full = (total_ff >= CNT_W'(MAX_BOXES));
   assign do_commit  = is_end && run_has_ff && !table_full;
   assign do_hide    = is_hide && sel_valid_ff;
   assign scan_done  = (state_ff == ST_SCAN) && probe_chain[MAX_BOXES].active;

   // probe launch into the first cell
   always_comb begin
      probe_chain[0].active = is_click;
      probe_chain[0].found  = 1'b0;
      x_chain[0]            = x_pt;
      y_chain[0]            = y_pt;
      idx_chain[0]          = '0;
   end

   // entry cells
   for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
      bht_cell #(
         .CW    (CW),
         .IW    (IW),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .commit_en  (do_commit && (total_ff == CNT_W'(i))),
         .commit_box ({run_xmin_ff, run_xmax_ff, run_ymin_ff, run_ymax_ff}),
         .hide_en    (do_hide && (sel_idx_ff == IW'(i))),
         .probe_in   (probe_chain[i]),
         .x_in       (x_chain[i]),
         .y_in       (y_chain[i]),
         .idx_in     (idx_chain[i]),
         .probe_out  (probe_chain[i+1]),
         .x_out      (x_chain[i+1]),
         .y_out      (y_chain[i+1]),
         .idx_out    (idx_chain[i+1])
      );
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_click) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // running box and build flag
   always_comb begin
      building_in = building_ff;
      run_has_in  = run_has_ff;
      run_xmin_in = run_xmin_ff;
      run_xmax_in = run_xmax_ff;
      run_ymin_in = run_ymin_ff;
      run_ymax_in = run_ymax_ff;
      if (is_start) begin
         building_in = 1'b1;
      end
      if (is_end) begin
         building_in = 1'b0;
         run_has_in  = 1'b0;
      end
      if (is_click && building_ff) begin
         run_has_in = 1'b1;
         if (!run_has_ff) begin
            run_xmin_in = x_pt;
            run_xmax_in = x_pt;
            run_ymin_in = y_pt;
            run_ymax_in = y_pt;
         end else begin
            if (x_pt < run_xmin_ff) run_xmin_in = x_pt;
            if (x_pt > run_xmax_ff) run_xmax_in = x_pt;
            if (y_pt < run_ymin_ff) run_ymin_in = y_pt;
            if (y_pt > run_ymax_ff) run_ymax_in = y_pt;
         end
      end
   end

   // table count and selection
   always_comb begin
      total_in     = do_commit ? total_ff + CNT_W'(1) : total_ff;
      sel_valid_in = sel_valid_ff;
      sel_idx_in   = sel_idx_ff;
      if (scan_done) begin
         sel_valid_in = probe_chain[MAX_BOXES].found;
         sel_idx_in   = probe_chain[MAX_BOXES].found ? idx_chain[MAX_BOXES] : '0;
      end
   end

   // status for non-click requests
   always_comb begin
      stat = bht_pkg::STAT_OK;
      if (is_end && !run_has_ff) begin
         stat = bht_pkg::STAT_EMPTY;
      end else if (is_end && table_full) begin
         stat = bht_pkg::STAT_FULL;
      end else if (is_hide && !sel_valid_ff) begin
         stat = bht_pkg::STAT_NO_SEL;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (scan_done) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.hit_found = sel_valid_in;
         rsp_data_in.hit_index = bht_pkg::INDEX_W'(sel_idx_in);
         rsp_data_in.box_count = bht_pkg::COUNT_W'(total_ff);
         rsp_data_in.status    = bht_pkg::STAT_OK;
      end else if (req_fire && !is_click) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.hit_found = sel_valid_ff;
         rsp_data_in.hit_index = sel_valid_ff ? bht_pkg::INDEX_W'(sel_idx_ff) : '0;
         rsp_data_in.box_count = bht_pkg::COUNT_W'(total_in);
         rsp_data_in.status    = stat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         building_ff  <= 1'b0;
         run_has_ff   <= 1'b0;
         total_ff     <= '0;
         sel_valid_ff <= 1'b0;
         sel_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         building_ff  <= building_in;
         run_has_ff   <= run_has_in;
         total_ff     <= total_in;
         sel_valid_ff <= sel_valid_in;
         sel_idx_ff   <= sel_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      run_xmin_ff <= run_xmin_in;
      run_xmax_ff <= run_xmax_in;
      run_ymin_ff <= run_ymin_in;
      run_ymax_ff <= run_ymax_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bht_checker.sv =====
// Port-level checks for the hit test table, bound to the top level.
`default_nettype none

module bht_checker #(
   parameter int MAX_BOXES = bht_pkg::MAX_BOXES
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire bht_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire bht_pkg::rsp_type rsp_data
);

   // a parked result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   // no request taken while a result is parked
   a_no_accept_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while result stalled");

   // index reads zero without a selection
   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit_found |-> rsp_data.hit_index == '0)
      else $error("hit_index set without a selection");

   // full status only with a full table
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == bht_pkg::STAT_FULL) |->
         rsp_data.box_count == bht_pkg::COUNT_W'(MAX_BOXES))
      else $error("full status with table not full");

   // a click blocks new requests in the cycle after it is taken
   a_click_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.opcode == bht_pkg::OP_CLICK) |=> !req_ready)
      else $error("request taken during a click scan");

endmodule

bind box_hit_test_table bht_checker #(
   .MAX_BOXES (MAX_BOXES)
) u_bht_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
